FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while in reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/hcl_pkg.sv
package hcl_pkg;

    // angle datapath
    localparam int CORDIC_STEPS = 24;
    localparam int ANGLE_W      = 32;
    localparam int XY_W         = 34;
    localparam int PRE_SHIFT_Q  = 30;

    // ratio and exponent datapath
    localparam int W_W = 31;
    localparam int T_W = 25;
    localparam int Q_W = 31;
    localparam logic [T_W-1:0] EXP_K     = 25'd32212255;
    localparam logic [31:0]    RECIP3    = 32'hAAAAAAAB;
    localparam logic [29:0]    LUM_RECIP = 30'd1012096000;

    // output fields
    localparam int HUE_W      = 16;
    localparam int OUT_W      = 17;
    localparam int OUT_DATA_W = 56;
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // stage counts of the sub units
    localparam int CORDIC_LAT = CORDIC_STEPS + 3;
    localparam int DIVEXP_LAT = W_W + 9;
    localparam int CDIV_LAT   = 3;

    typedef logic [ANGLE_W-1:0] angle_t;

    // atan(2^-i) as a fraction of a turn, Q0.32
    function automatic angle_t turn_step(input logic [4:0] i);
        angle_t r;
        case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/hcl_cordic.sv
module hcl_cordic
    import hcl_pkg::*;
(
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [XY_W-1:0]  x_in,
    input  logic signed [XY_W-1:0]  y_in,
    input  angle_t                  z_in,
    input  logic                    grey_in,
    output logic [HUE_W-1:0]        hue,
    output logic                    grey
);

    logic signed [XY_W-1:0] x_reg [1:CORDIC_STEPS];
    logic signed [XY_W-1:0] y_reg [1:CORDIC_STEPS];
    angle_t                 z_reg [1:CORDIC_STEPS];
    logic                   g_reg [1:CORDIC_STEPS];

    // vectoring steps, one per register stage
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [XY_W-1:0] xi;
        logic signed [XY_W-1:0] yi;
        angle_t                 zi;
        logic                   gi;
        if (i == 0) begin : g_first
            assign xi = x_in;
            assign yi = y_in;
            assign zi = z_in;
            assign gi = grey_in;
        end else begin : g_rest
            assign xi = x_reg[i];
            assign yi = y_reg[i];
            assign zi = z_reg[i];
            assign gi = g_reg[i];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                g_reg[i+1] <= gi;
                if (yi > 0) begin
                    x_reg[i+1] <= xi + (yi >>> i);
                    y_reg[i+1] <= yi - (xi >>> i);
                    z_reg[i+1] <= zi + turn_step(5'(i));
                end else begin
                    x_reg[i+1] <= xi - (yi >>> i);
                    y_reg[i+1] <= yi + (xi >>> i);
                    z_reg[i+1] <= zi - turn_step(5'(i));
                end
            end
        end
    end

    // fold: distance of the doubled angle to the nearest whole turn
    angle_t a_dbl;
    angle_t a_neg;
    angle_t m_next;
    always_comb begin
        a_dbl = z_reg[CORDIC_STEPS] << 1;
        a_neg = angle_t'(0) - a_dbl;
        if (a_dbl == '0) begin
            m_next = '0;
        end else begin
            m_next = (a_dbl < a_neg) ? a_dbl : a_neg;
        end
    end

    angle_t        a1_reg, m1_reg, a2_reg;
    logic [63:0]   p6_reg;
    logic          g1_reg, g2_reg, g3_reg;
    logic [HUE_W-1:0] hue_reg;
    logic [ANGLE_W:0] h_sum;

    // floor(m/6) by reciprocal, then offset and round to 16 bits
    always_comb begin
        h_sum = {1'b0, a2_reg - {2'b00, p6_reg[63:34]}} + (ANGLE_W+1)'(32'h8000);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg  <= z_reg[CORDIC_STEPS];
            m1_reg  <= m_next;
            g1_reg  <= g_reg[CORDIC_STEPS];
            a2_reg  <= a1_reg;
            p6_reg  <= 64'(m1_reg) * 64'(RECIP3);
            g2_reg  <= g1_reg;
            hue_reg <= g2_reg ? '0 : h_sum[31:16];
            g3_reg  <= g2_reg;
        end
    end

    assign hue  = hue_reg;
    assign grey = g3_reg;

endmodule

FILE: sv/hcl_div_exp.sv
module hcl_div_exp
    import hcl_pkg::*;
#(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [CHANNEL_BITS-1:0] u_in,
    input  logic [CHANNEL_BITS-1:0] v_in,
    output logic [CHANNEL_BITS-1:0] u_out,
    output logic [CHANNEL_BITS-1:0] v_out,
    output logic [Q_W-1:0]          q
);

    localparam int CB = CHANNEL_BITS;
    localparam logic [Q_W-1:0] ONE = Q_W'(32'h4000_0000);

    logic [CB-1:0]  rem_reg [1:W_W];
    logic [W_W-1:0] wq_reg  [1:W_W];
    logic [CB-1:0]  dv_reg  [1:W_W];
    logic [CB-1:0]  ud_reg  [1:W_W];
    logic [CB-1:0]  vd_reg  [1:W_W];

    // restoring division u*2^30/v, one quotient bit per stage
    for (genvar j = 0; j < W_W; j++) begin : g_div
        logic [CB-1:0]  rem_i, dv_i, u_i, v_i;
        logic [W_W-1:0] wq_i;
        logic [CB:0]    sh;
        logic [CB:0]    diff;
        logic           ge;
        if (j == 0) begin : g_first
            // a black pixel divides 1 by 1
            assign rem_i = (v_in == '0) ? CB'(1) : u_in;
            assign dv_i  = (v_in == '0) ? CB'(1) : v_in;
            assign wq_i  = '0;
            assign u_i   = u_in;
            assign v_i   = v_in;
            assign sh    = {1'b0, rem_i};
        end else begin : g_rest
            assign rem_i = rem_reg[j];
            assign dv_i  = dv_reg[j];
            assign wq_i  = wq_reg[j];
            assign u_i   = ud_reg[j];
            assign v_i   = vd_reg[j];
            assign sh    = {rem_i, 1'b0};
        end
        assign ge   = (sh >= {1'b0, dv_i});
        assign diff = sh - {1'b0, dv_i};
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j+1] <= ge ? diff[CB-1:0] : sh[CB-1:0];
                wq_reg[j+1]  <= {wq_i[W_W-2:0], ge};
                dv_reg[j+1]  <= dv_i;
                ud_reg[j+1]  <= u_i;
                vd_reg[j+1]  <= v_i;
            end
        end
    end

    // exp series by Horner, each product registered
    logic [W_W+T_W-1:0] e1_reg;
    logic [T_W-1:0]     t2_reg, t3_reg, t4_reg, t5_reg, t6_reg, t7_reg;
    logic [Q_W-1:0]     p1_reg, p2_reg, p3_reg, q_reg;
    logic [T_W+Q_W-1:0] pr1_reg, pr2_reg, pr3_reg;
    logic [57:0]        mr_reg;
    logic [CB-1:0]      ue_reg [0:8];
    logic [CB-1:0]      ve_reg [0:8];
    logic [T_W-1:0]     t_new;

    assign t_new = e1_reg[54:30];

    always_ff @(posedge aclk) begin
        if (en) begin
            e1_reg  <= (W_W+T_W)'(wq_reg[W_W]) * (W_W+T_W)'(EXP_K);
            t2_reg  <= t_new;
            p1_reg  <= ONE + Q_W'(t_new >> 2);
            t3_reg  <= t2_reg;
            pr1_reg <= (T_W+Q_W)'(t2_reg) * (T_W+Q_W)'(p1_reg);
            t4_reg  <= t3_reg;
            mr_reg  <= 58'(pr1_reg[55:30]) * 58'(RECIP3);
            t5_reg  <= t4_reg;
            p2_reg  <= ONE + Q_W'(mr_reg[57:33]);
            t6_reg  <= t5_reg;
            pr2_reg <= (T_W+Q_W)'(t5_reg) * (T_W+Q_W)'(p2_reg);
            t7_reg  <= t6_reg;
            p3_reg  <= ONE + Q_W'(pr2_reg[55:31]);
            pr3_reg <= (T_W+Q_W)'(t7_reg) * (T_W+Q_W)'(p3_reg);
            q_reg   <= ONE + Q_W'(pr3_reg[55:30]);
        end
    end

    // channel extremes follow the exponent stages
    always_ff @(posedge aclk) begin
        if (en) begin
            ue_reg[0] <= ud_reg[W_W];
            ve_reg[0] <= vd_reg[W_W];
            for (int k = 1; k < 9; k++) begin
                ue_reg[k] <= ue_reg[k-1];
                ve_reg[k] <= ve_reg[k-1];
            end
        end
    end

    assign u_out = ue_reg[8];
    assign v_out = ve_reg[8];
    assign q     = q_reg;

endmodule

FILE: sv/hcl_cdiv.sv
module hcl_cdiv
    import hcl_pkg::*;
#(
    parameter int CHANNEL_BITS = 16,
    parameter int X_W          = 34
) (
    input  logic                             aclk,
    input  logic                             en,
    input  logic [X_W-1:0]                   x,
    output logic [X_W-CHANNEL_BITS:0]        quo
);

    localparam int CB   = CHANNEL_BITS;
    localparam int S    = X_W + 2;
    localparam int M_W  = S - CB + 1;
    localparam int QO_W = X_W - CB + 1;
    localparam int LO_W = X_W / 2;
    localparam int HI_W = X_W - LO_W;
    localparam int P_W  = X_W + M_W;
    localparam int R_W  = X_W + 1;
    localparam logic [63:0]    M_FULL = (64'd1 << S) / ((64'd1 << CB) - 64'd1);
    localparam logic [M_W-1:0] M      = M_FULL[M_W-1:0];
    localparam logic [R_W-1:0] F_R    = R_W'((64'd1 << CB) - 64'd1);

    logic [LO_W+M_W-1:0] plo_reg;
    logic [HI_W+M_W-1:0] phi_reg;
    logic [X_W-1:0]      x1_reg, x2_reg;
    logic [QO_W-1:0]     qe_reg, quo_reg;
    logic [P_W-1:0]      p_sum;
    logic [R_W-1:0]      qf, r;
    logic                ge;

    // reciprocal product in two halves, then a single correction step
    always_comb begin
        p_sum = (P_W'(phi_reg) << LO_W) + P_W'(plo_reg);
        qf    = (R_W'(qe_reg) << CB) - R_W'(qe_reg);
        r     = R_W'(x2_reg) - qf;
        ge    = (r >= F_R);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            plo_reg <= (LO_W+M_W)'(x[LO_W-1:0]) * (LO_W+M_W)'(M);
            phi_reg <= (HI_W+M_W)'(x[X_W-1:LO_W]) * (HI_W+M_W)'(M);
            x1_reg  <= x;
            qe_reg  <= QO_W'(p_sum >> S);
            x2_reg  <= x1_reg;
            quo_reg <= qe_reg + QO_W'(ge);
        end
    end

    assign quo = quo_reg;

endmodule

FILE: sv/rgb_to_hcl_conversion_core.sv
// channel   | direction | tdata fields (low bit up)                | width
// s_axis    | in        | red, green, blue (CHANNEL_BITS each)     | 3*CB padded to bytes
// m_axis    | out       | hue[15:0], chroma[32:16], luminance[49:33] | 56
//
// fully pipelined, one pixel per clock unless m_tready stalls the output
// the longest path runs through the 31-stage ratio divider and the 9-stage exponent series
// aresetn clears only the valid bits; payload registers are not reset
// a stall on m_tready freezes every stage at once, nothing is lost or repeated
module rgb_to_hcl_conversion_core
    import hcl_pkg::*;
#(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // red, green, blue
    input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]     s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // hue, chroma, luminance, zero pad
    output logic [OUT_DATA_W-1:0]                   m_tdata
);

`include "assert_macros.svh"

    localparam int CB       = CHANNEL_BITS;
    localparam int SHIFT    = PRE_SHIFT_Q - CB;
    localparam int K_H      = 1 + CORDIC_LAT;
    localparam int K_Q      = 1 + DIVEXP_LAT;
    localparam int K_C      = K_Q + 2 + CDIV_LAT;
    localparam int K_OUT    = K_C + 2;
    localparam int LAT      = K_OUT + 1;
    localparam int HUE_DLY  = K_OUT - K_H - 1;
    localparam int GC_N     = K_OUT - K_Q;
    localparam int CX_W     = CB + 18;
    localparam int LX_W     = CB + 28;
    localparam int CQ_W     = CX_W - CB + 1;
    localparam int LQ_W     = LX_W - CB + 1;
    localparam logic [CB+31:0] C_BIAS = (CB+32)'(((64'd1 << CB) - 64'd1) << 13);

    // valid bits and global stage enable
    logic [LAT-1:0] vld_reg, vld_next;
    logic           en;

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];
    assign vld_next = {vld_reg[LAT-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // input beat register
    logic [CB-1:0] r_reg, g_reg, b_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg <= s_tdata[CB-1:0];
            g_reg <= s_tdata[2*CB-1:CB];
            b_reg <= s_tdata[3*CB-1:2*CB];
        end
    end

    // extremes and the starting vector, folded into the right half plane
    logic [CB-1:0]          u_next, v_next, u_reg, v_reg;
    logic signed [XY_W-1:0] xs, ys, x_next, y_next, x_reg, y_reg;
    angle_t                 z_next, z_reg;
    logic                   grey_reg;

    always_comb begin
        u_next = r_reg;
        v_next = r_reg;
        if (g_reg < u_next) u_next = g_reg;
        if (b_reg < u_next) u_next = b_reg;
        if (g_reg > v_next) v_next = g_reg;
        if (b_reg > v_next) v_next = b_reg;
        xs = XY_W'($signed({1'b0, r_reg}) - $signed({1'b0, g_reg})) <<< SHIFT;
        ys = XY_W'($signed({1'b0, g_reg}) - $signed({1'b0, b_reg})) <<< SHIFT;
        if (xs < 0) begin
            x_next = -xs;
            y_next = -ys;
            z_next = angle_t'(32'h8000_0000);
        end else begin
            x_next = xs;
            y_next = ys;
            z_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg    <= u_next;
            v_reg    <= v_next;
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            grey_reg <= (u_next == v_next);
        end
    end

    // hue path
    logic [HUE_W-1:0] hue_c;
    logic             grey_h;

    hcl_cordic u_cordic (
        .aclk    (aclk),
        .en      (en),
        .x_in    (x_reg),
        .y_in    (y_reg),
        .z_in    (z_reg),
        .grey_in (grey_reg),
        .hue     (hue_c),
        .grey    (grey_h)
    );

    // ratio and exponent path
    logic [CB-1:0]  uq, vq;
    logic [Q_W-1:0] q;

    hcl_div_exp #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_div_exp (
        .aclk  (aclk),
        .en    (en),
        .u_in  (u_reg),
        .v_in  (v_reg),
        .u_out (uq),
        .v_out (vq),
        .q     (q)
    );

    // chroma and luminance products
    logic [CB+30:0] cp_reg;
    logic [CB+31:0] lp_reg;
    logic [CB-1:0]  ul_reg;
    logic [CX_W-1:0] c1_reg;
    logic [LX_W-1:0] x2_reg;
    logic [CB+31:0] c_sum, n_val;
    logic           gc_reg [0:GC_N-1];

    always_comb begin
        c_sum = (CB+32)'(cp_reg) + C_BIAS;
        n_val = lp_reg - ((CB+32)'(ul_reg) << 30);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cp_reg <= (CB+31)'(vq - uq) * (CB+31)'(q);
            lp_reg <= (CB+32)'((CB+1)'(uq) + (CB+1)'(vq)) * (CB+32)'(q);
            ul_reg <= uq;
            c1_reg <= c_sum[CB+31:14];
            x2_reg <= n_val[CB+31:4];
            gc_reg[0] <= (uq == vq);
            for (int k = 1; k < GC_N; k++) begin
                gc_reg[k] <= gc_reg[k-1];
            end
        end
    end

    // scale by 1/(2^CB - 1)
    logic [CQ_W-1:0] chroma_q;
    logic [LQ_W-1:0] lum_s;

    hcl_cdiv #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .X_W          (CX_W)
    ) u_cdiv_chroma (
        .aclk (aclk),
        .en   (en),
        .x    (c1_reg),
        .quo  (chroma_q)
    );

    hcl_cdiv #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .X_W          (LX_W)
    ) u_cdiv_lum (
        .aclk (aclk),
        .en   (en),
        .x    (x2_reg),
        .quo  (lum_s)
    );

    // luminance weight, rounding and saturation
    logic [LQ_W+29:0]  lprod_reg;
    logic [LQ_W+30:0]  l_sum;
    logic [LQ_W-10:0]  l_raw;
    logic [OUT_W-1:0]  chroma_sat_reg;
    logic [HUE_W-1:0]  hd_reg [0:HUE_DLY-1];
    logic              ghd_reg [0:HUE_DLY-1];
    logic [HUE_W-1:0]  hue_out_reg;
    logic [OUT_W-1:0]  chroma_out_reg, lum_out_reg;
    logic              gh_out_reg;

    always_comb begin
        l_sum = (LQ_W+31)'(lprod_reg) + ((LQ_W+31)'(1) << 39);
        l_raw = l_sum[LQ_W+30:40];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lprod_reg      <= (LQ_W+30)'(lum_s) * (LQ_W+30)'(LUM_RECIP);
            chroma_sat_reg <= (chroma_q > CQ_W'(OUT_MAX)) ? OUT_MAX : chroma_q[OUT_W-1:0];
            hd_reg[0]      <= hue_c;
            ghd_reg[0]     <= grey_h;
            for (int k = 1; k < HUE_DLY; k++) begin
                hd_reg[k]  <= hd_reg[k-1];
                ghd_reg[k] <= ghd_reg[k-1];
            end
            hue_out_reg    <= hd_reg[HUE_DLY-1];
            gh_out_reg     <= ghd_reg[HUE_DLY-1];
            chroma_out_reg <= chroma_sat_reg;
            lum_out_reg    <= (l_raw > (LQ_W-9)'(OUT_MAX)) ? OUT_MAX : l_raw[OUT_W-1:0];
        end
    end

    assign m_tdata = {6'b0, lum_out_reg, chroma_out_reg, hue_out_reg};

    // checks
    `ASSERT_NEXT(a_stall_freeze, !en, $stable(vld_reg), "pipeline moved during a stall")
    `ASSERT_NEXT(a_beat_taken, s_tvalid && s_tready, vld_reg[0], "accepted beat not registered")
    `ASSERT_IMP(a_path_align, m_tvalid, gh_out_reg == gc_reg[GC_N-1], "hue and chroma paths out of step")

endmodule
